// File: hw/rtl/brf_pkg.sv
// Shared types and constants of the bus register file.
// Event codes, register indexes, read image layout and pipeline structs.
// No dependencies.
package brf_pkg;

	typedef enum logic [2:0] {
		OP_TICK      = 3'd0,
		OP_RX_ADDR   = 3'd1,
		OP_RX_BYTE   = 3'd2,
		OP_TX_ADDR   = 3'd3,
		OP_TX_BYTE   = 3'd4,
		OP_ACK_ONLY  = 3'd5,
		OP_BUS_ERR   = 3'd6,
		OP_SENSOR_WR = 3'd7
	} op_t;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_SECOND = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SAFE_SECONDS     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LED_LIT_TICKS    = 2'd2;

	localparam logic [7:0]  TPS_RESET  = 8'd47;
	localparam logic [15:0] SAFE_RESET = 16'd60;
	localparam logic [7:0]  LED_RESET  = 8'd6;

	localparam int TAIL_BYTES = 16;
	localparam logic [7:0] CMD_SET_RELAYS = 8'h01;
	localparam logic [3:0] RELAY_FIELD = 4'hF;
	localparam logic [7:0] TAIL_MARK_LO = 8'h55;
	localparam logic [7:0] TAIL_MARK_HI = 8'hAA;
	localparam logic [7:0] READ_BEYOND = 8'hFF;

	localparam logic [1:0] RX_IDLE = 2'd0;
	localparam logic [1:0] RX_CMD  = 2'd1;
	localparam logic [1:0] RX_DONE = 2'd2;

	typedef struct packed {
		logic       sel_mem;
		logic [7:0] tail_byte;
		logic       ack;
		logic       bus_release;
		logic [3:0] relay_bits;
		logic       led_lit;
	} res_t;

	typedef struct packed {
		logic [7:0] read_byte;
		logic       ack;
		logic       bus_release;
		logic [3:0] relay_bits;
		logic       led_lit;
	} rsp_t;

endpackage

// File: hw/rtl/brf_ifs.sv
// Channel interfaces of the bus register file: events in, results out, register writes.
// Depends on brf_pkg.
interface brf_req_if;
	logic       valid;
	logic       ready;
	logic [2:0] op;
	logic [7:0] data_byte;
	logic [6:0] sensor_offset;
	modport source (output valid, op, data_byte, sensor_offset, input ready);
	modport sink (input valid, op, data_byte, sensor_offset, output ready);
endinterface

interface brf_rsp_if;
	logic       valid;
	logic       ready;
	logic [7:0] read_byte;
	logic       ack;
	logic       bus_release;
	logic [3:0] relay_bits;
	logic       led_lit;
	modport source (output valid, read_byte, ack, bus_release, relay_bits, led_lit,
		input ready);
	modport sink (input valid, read_byte, ack, bus_release, relay_bits, led_lit,
		output ready);
endinterface

interface brf_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [brf_pkg::CFG_IDX_W-1:0]   index;
	logic [brf_pkg::CFG_DATA_W-1:0]  wdata;
	modport source (output valid, index, wdata, input ready);
	modport sink (input valid, index, wdata, output ready);
endinterface

// File: hw/rtl/brf_sensor_mem.sv
// Sensor byte store: one write port, one registered read port, per-entry valid bits.
// Entries never written read as zero. No package dependencies.
module brf_sensor_mem #(
	parameter int SENSOR_BYTES = 128
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            we,
	input  logic [$clog2(SENSOR_BYTES)-1:0] waddr,
	input  logic [7:0]                      wdata,
	input  logic                            re,
	input  logic [$clog2(SENSOR_BYTES)-1:0] raddr,
	output logic [7:0]                      rdata
);
	logic [7:0]              mem [SENSOR_BYTES];
	logic [SENSOR_BYTES-1:0] vld_q;
	logic [7:0]              rdata_q;
	logic                    rvld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				rvld_q <= vld_q[raddr];
			end
		end
	end

	assign rdata = rvld_q ? rdata_q : 8'h00;
endmodule

// File: hw/rtl/brf_core.sv
// Event engine: bus state, read pointer, second counter, timeout and indicator.
// Issues sensor store accesses and builds the result of each transaction. Depends on brf_pkg.
module brf_core #(
	parameter int SENSOR_BYTES = 128
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            take,
	input  logic [2:0]                      op,
	input  logic [7:0]                      data_byte,
	input  logic [6:0]                      sensor_offset,
	input  logic [7:0]                      ticks_per_second,
	input  logic [15:0]                     safe_seconds,
	input  logic [7:0]                      led_lit_ticks,
	output logic                            mem_we,
	output logic [$clog2(SENSOR_BYTES)-1:0] mem_waddr,
	output logic [7:0]                      mem_wdata,
	output logic                            mem_re,
	output logic [$clog2(SENSOR_BYTES)-1:0] mem_raddr,
	output brf_pkg::res_t                   res
);
	localparam int AW = $clog2(SENSOR_BYTES);
	localparam int IMAGE_BYTES = SENSOR_BYTES + brf_pkg::TAIL_BYTES;
	localparam int PW = $clog2(IMAGE_BYTES + 1);

	logic [7:0]    cmd_q, cmd_n;
	logic [1:0]    rx_q, rx_n;
	logic [PW-1:0] ptr_q, ptr_n;
	logic [3:0]    relay_q, relay_n;
	logic [31:0]   sec_q, sec_n;
	logic [31:0]   last_q, last_n;
	logic [7:0]    presc_q, presc_n;
	logic          led_q, led_n;

	logic [7:0]    off_ext;
	logic [PW-1:0] ptr_inc;
	logic [PW-1:0] tail_pos;
	logic [7:0]    tail_val;
	logic [31:0]   sec_inc;
	logic [31:0]   idle_secs;
	brf_pkg::op_t  op_e;

	assign off_ext   = {1'b0, sensor_offset};
	assign ptr_inc   = ptr_q + PW'(1);
	assign tail_pos  = ptr_q - PW'(SENSOR_BYTES);
	assign sec_inc   = sec_q + 32'd1;
	assign idle_secs = sec_inc - last_q;
	assign op_e      = brf_pkg::op_t'(op);

	always_comb begin
		case (tail_pos[3:0]) inside
			4'd0:          tail_val = {4'h0, relay_q};
			[4'd1:4'd5]:   tail_val = 8'h00;
			4'd6:          tail_val = last_q[7:0];
			4'd7:          tail_val = last_q[15:8];
			4'd8:          tail_val = last_q[23:16];
			4'd9:          tail_val = last_q[31:24];
			4'd10:         tail_val = sec_q[7:0];
			4'd11:         tail_val = sec_q[15:8];
			4'd12:         tail_val = sec_q[23:16];
			4'd13:         tail_val = sec_q[31:24];
			4'd14:         tail_val = brf_pkg::TAIL_MARK_LO;
			default:       tail_val = brf_pkg::TAIL_MARK_HI;
		endcase
	end

	always_comb begin
		cmd_n     = cmd_q;
		rx_n      = rx_q;
		ptr_n     = ptr_q;
		relay_n   = relay_q;
		sec_n     = sec_q;
		last_n    = last_q;
		presc_n   = presc_q;
		led_n     = led_q;
		mem_we    = 1'b0;
		mem_waddr = off_ext[AW-1:0];
		mem_wdata = data_byte;
		mem_re    = 1'b0;
		mem_raddr = '0;
		res       = '0;
		unique case (op_e)
			brf_pkg::OP_TICK: begin
				if (presc_q == ticks_per_second - 8'd1) begin
					presc_n = 8'd0;
					sec_n   = sec_inc;
					led_n   = 1'b1;
					if (idle_secs > {16'h0000, safe_seconds}) begin
						relay_n = 4'h0;
					end
				end else begin
					presc_n = presc_q + 8'd1;
				end
				if (presc_n >= led_lit_ticks) begin
					led_n = 1'b0;
				end
			end
			brf_pkg::OP_RX_ADDR: begin
				rx_n    = brf_pkg::RX_IDLE;
				last_n  = sec_q;
				res.ack = 1'b1;
			end
			brf_pkg::OP_RX_BYTE: begin
				if (rx_q == brf_pkg::RX_IDLE) begin
					cmd_n   = data_byte;
					rx_n    = brf_pkg::RX_CMD;
					res.ack = 1'b1;
				end else if (rx_q == brf_pkg::RX_CMD) begin
					rx_n = brf_pkg::RX_DONE;
					if (cmd_q == brf_pkg::CMD_SET_RELAYS) begin
						relay_n = data_byte[3:0] & brf_pkg::RELAY_FIELD;
					end
				end
			end
			brf_pkg::OP_TX_ADDR: begin
				mem_re      = 1'b1;
				res.sel_mem = 1'b1;
				ptr_n       = PW'(1);
				last_n      = sec_q;
				res.ack     = 1'b1;
			end
			brf_pkg::OP_TX_BYTE: begin
				if (ptr_q < PW'(IMAGE_BYTES)) begin
					ptr_n   = ptr_inc;
					res.ack = (ptr_inc < PW'(IMAGE_BYTES));
					if (ptr_q < PW'(SENSOR_BYTES)) begin
						mem_re      = 1'b1;
						mem_raddr   = ptr_q[AW-1:0];
						res.sel_mem = 1'b1;
					end else begin
						res.tail_byte = tail_val;
					end
				end else begin
					res.tail_byte = brf_pkg::READ_BEYOND;
				end
			end
			brf_pkg::OP_ACK_ONLY: begin
				res.ack = 1'b1;
			end
			brf_pkg::OP_BUS_ERR: begin
				res.ack         = 1'b1;
				res.bus_release = 1'b1;
			end
			brf_pkg::OP_SENSOR_WR: begin
				mem_we = (int'(off_ext) < SENSOR_BYTES);
			end
			default: begin
			end
		endcase
		res.relay_bits = relay_n;
		res.led_lit    = led_n;
		if (!take) begin
			mem_we = 1'b0;
			mem_re = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q   <= 8'h00;
			rx_q    <= brf_pkg::RX_IDLE;
			ptr_q   <= '0;
			relay_q <= 4'h0;
			sec_q   <= 32'd0;
			last_q  <= 32'd0;
			presc_q <= 8'd0;
			led_q   <= 1'b1;
		end else if (take) begin
			cmd_q   <= cmd_n;
			rx_q    <= rx_n;
			ptr_q   <= ptr_n;
			relay_q <= relay_n;
			sec_q   <= sec_n;
			last_q  <= last_n;
			presc_q <= presc_n;
			led_q   <= led_n;
		end
	end

	a_ptr_in_image: assert property (@(posedge clk) disable iff (!arst_n)
		ptr_q <= PW'(IMAGE_BYTES))
		else $error("read pointer beyond image");
	a_rx_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		rx_q != 2'd3)
		else $error("receive count out of range");
endmodule

// File: hw/rtl/bus_register_file_with_safe_timeout.sv
// Top level of the slave-side bus register file with relay safety timeout.
// Depends on brf_pkg, brf_ifs, brf_sensor_mem and brf_core.
//
// Usage:
//   req  - one transaction per bus event, timer tick or sensor byte write
//          (op, data_byte, sensor_offset).
//   rsp  - exactly one transaction per request: read_byte, ack, bus_release,
//          relay_bits and led_lit as they stand after the event.
//   cfg  - register writes (index 0 ticks_per_second, 1 safe_seconds, 2 led_lit_ticks),
//          always ready; the user must write only while idle, the block does not enforce it.
// The sensor store read is registered and followed by the result register.
// Throughput: one request per cycle while rsp.ready holds; scalar state updates at accept, so
// consecutive requests need no interlock.
// Stall: a result waiting on rsp holds while one further request is taken
// into the read stage; req.ready drops only when both stages are full.
// Reset: the sensor store reads as zero, relays open, counters zero,
// indicator lit, registers at their defaults. No clearing pass is needed.
module bus_register_file_with_safe_timeout #(
	parameter int SENSOR_BYTES = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	brf_req_if.sink     req,
	brf_rsp_if.source   rsp,
	brf_cfg_if.sink     cfg
);
	localparam int AW = $clog2(SENSOR_BYTES);

	logic [7:0]  tps_q;
	logic [15:0] safe_q;
	logic [7:0]  led_ticks_q;

	logic          take;
	logic          s1_v_s1;
	brf_pkg::res_t res;
	brf_pkg::res_t res_s1;
	logic          s1_adv;
	logic          out_v_q;
	brf_pkg::rsp_t out_q;

	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	logic [7:0]    mem_wdata;
	logic          mem_re;
	logic [AW-1:0] mem_raddr;
	logic [7:0]    mem_rdata;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tps_q       <= brf_pkg::TPS_RESET;
			safe_q      <= brf_pkg::SAFE_RESET;
			led_ticks_q <= brf_pkg::LED_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				brf_pkg::CFG_TICKS_PER_SECOND: tps_q       <= cfg.wdata[7:0];
				brf_pkg::CFG_SAFE_SECONDS:     safe_q      <= cfg.wdata;
				brf_pkg::CFG_LED_LIT_TICKS:    led_ticks_q <= cfg.wdata[7:0];
				default: begin
				end
			endcase
		end
	end

	assign s1_adv    = s1_v_s1 && (!out_v_q || rsp.ready);
	assign req.ready = !s1_v_s1 || s1_adv;
	assign take      = req.valid && req.ready;

	brf_core #(
		.SENSOR_BYTES (SENSOR_BYTES)
	) u_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.take             (take),
		.op               (req.op),
		.data_byte        (req.data_byte),
		.sensor_offset    (req.sensor_offset),
		.ticks_per_second (tps_q),
		.safe_seconds     (safe_q),
		.led_lit_ticks    (led_ticks_q),
		.mem_we           (mem_we),
		.mem_waddr        (mem_waddr),
		.mem_wdata        (mem_wdata),
		.mem_re           (mem_re),
		.mem_raddr        (mem_raddr),
		.res              (res)
	);

	brf_sensor_mem #(
		.SENSOR_BYTES (SENSOR_BYTES)
	) u_mem (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.re     (mem_re),
		.raddr  (mem_raddr),
		.rdata  (mem_rdata)
	);

	always_ff @(posedge clk) begin
		if (take) begin
			res_s1 <= res;
		end
		if (s1_adv) begin
			out_q.read_byte   <= res_s1.sel_mem ? mem_rdata : res_s1.tail_byte;
			out_q.ack         <= res_s1.ack;
			out_q.bus_release <= res_s1.bus_release;
			out_q.relay_bits  <= res_s1.relay_bits;
			out_q.led_lit     <= res_s1.led_lit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_s1 <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (take) begin
				s1_v_s1 <= 1'b1;
			end else if (s1_adv) begin
				s1_v_s1 <= 1'b0;
			end
			if (s1_adv) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign rsp.valid       = out_v_q;
	assign rsp.read_byte   = out_q.read_byte;
	assign rsp.ack         = out_q.ack;
	assign rsp.bus_release = out_q.bus_release;
	assign rsp.relay_bits  = out_q.relay_bits;
	assign rsp.led_lit     = out_q.led_lit;

	a_full_blocks_req: assert property (@(posedge clk) disable iff (!arst_n)
		s1_v_s1 && out_v_q && !rsp.ready |-> !req.ready)
		else $error("request taken while both stages are full");
	a_out_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_v_q) |-> $past(s1_v_s1))
		else $error("result appeared without a pending transaction");
	a_release_acks: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && out_q.bus_release |-> out_q.ack)
		else $error("bus release without acknowledge");
endmodule
